>>> rtl/allocation_record_table_defines.svh
// ----------------------------------------------------------------------------
// Allocation record table: assertion macros
// Shared property forms used by the block's assertions.
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_RECORD_TABLE_DEFINES_SVH
`define ALLOCATION_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ART_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation record table package
// Field widths, command and status codes, channel payloads and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int DEPTH_DEFAULT     = 32;
    localparam int ADDR_BITS_DEFAULT = 32;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_APPEND = 3'd0;
    localparam mode_t MODE_FIND   = 3'd1;
    localparam mode_t MODE_FIT    = 3'd2;
    localparam mode_t MODE_REMOVE = 3'd3;
    localparam mode_t MODE_CLEAR  = 3'd4;
    localparam mode_t MODE_DUMP   = 3'd5;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_MISS = 2'd2;

    typedef struct packed {
        mode_t             mode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  rec_address;
        logic [LEN_W-1:0]   rec_length;
        status_t            status;
        logic [COUNT_W-1:0] removed;
        logic [COUNT_W-1:0] entries;
        logic               last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch command, reset walk counters
        logic exec;      // single-step commands
        logic scan;      // search / compaction walk
        logic dump_rd;   // read next record for dump
        logic dump_out;  // load dumped record into output register
        logic fin;       // load final result into output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t mode;
        logic  empty;
        logic  scan_done;
        logic  dump_last;
        logic  out_free;
    } dp_status_t;

endpackage

>>> rtl/art_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation record table channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface art_req_if;
    import art_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface art_rsp_if;
    import art_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/art_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation record table controller
// Sequences one command at a time through decode, walk and result load.
// ----------------------------------------------------------------------------
module art_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  art_pkg::dp_status_t   sts,
    output art_pkg::ctl_cmd_t     cmd
);
    import art_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (sts.mode == MODE_FIND || sts.mode == MODE_FIT ||
                             sts.mode == MODE_REMOVE)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.mode == MODE_DUMP && !sts.empty)
                begin
                    state_next = S_DUMP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_DUMP_RD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.dump_out = 1'b1;
                    state_next   = sts.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

>>> rtl/art_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation record table datapath
// Record memory, fill count, walk counters, compare and result registers.
// ----------------------------------------------------------------------------
module art_dp #(
    parameter int DEPTH     = art_pkg::DEPTH_DEFAULT,
    parameter int ADDR_BITS = art_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  art_pkg::req_t        req_data,
    input  art_pkg::ctl_cmd_t    cmd,
    output art_pkg::dp_status_t  sts,
    art_rsp_if.source            rsp
);
    import art_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int EW = AW + LEN_W;

    // record memory: {address, length}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] kept_reg;
    logic          pend_reg;
    logic          res_found_reg;
    logic          out_valid_reg;

    mode_t             mode_reg;
    logic [AW-1:0]     key_addr_reg;
    logic [LEN_W-1:0]  key_len_reg;
    logic [AW-1:0]     res_addr_reg;
    logic [LEN_W-1:0]  res_len_reg;
    status_t           res_status_reg;
    logic [CW-1:0]     res_removed_reg;
    rsp_t              out_reg;

    logic [AW-1:0]    ent_addr;
    logic [LEN_W-1:0] ent_len;
    logic             by_addr;
    logic             match_now;
    logic             stop_hit;
    logic             issue;
    logic             rd_en;
    logic             full;
    logic             app_we;
    logic             cmp_we;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [EW-1:0]    wdata;
    logic             scan_done;
    logic             dump_last;
    logic             out_free;

    assign ent_addr  = rdata_reg[EW-1 -: AW];
    assign ent_len   = rdata_reg[LEN_W-1:0];
    assign by_addr   = (mode_reg == MODE_FIND) || (mode_reg == MODE_REMOVE);
    assign match_now = pend_reg && (by_addr ? (ent_addr == key_addr_reg)
                                            : (ent_len >= key_len_reg));
    // find / first fit stop at the first hit; remove walks everything
    assign stop_hit  = match_now && (mode_reg != MODE_REMOVE);
    assign issue     = cmd.scan && (rd_idx_reg < count_reg) && !res_found_reg && !stop_hit;
    assign rd_en     = issue || cmd.dump_rd;
    assign scan_done = !pend_reg && ((rd_idx_reg >= count_reg) || res_found_reg);
    assign dump_last = (rd_idx_reg == count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;

    // compaction writes land at kept index, always behind the read index
    assign app_we = cmd.exec && (mode_reg == MODE_APPEND) && !full;
    assign cmp_we = cmd.scan && pend_reg && (mode_reg == MODE_REMOVE) && !match_now;
    assign we     = app_we || cmp_we;
    assign waddr  = app_we ? count_reg[IW-1:0] : kept_reg[IW-1:0];
    assign wdata  = app_we ? {key_addr_reg, key_len_reg} : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            kept_reg      <= '0;
            pend_reg      <= 1'b0;
            res_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;

            if (cmd.load)
            begin
                rd_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end

            if (cmd.load)
            begin
                kept_reg <= '0;
            end
            else if (cmp_we)
            begin
                kept_reg <= kept_reg + CW'(1);
            end

            if (cmd.load)
            begin
                res_found_reg <= 1'b0;
            end
            else if (cmd.scan && stop_hit)
            begin
                res_found_reg <= 1'b1;
            end

            priority if (app_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.exec && mode_reg == MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (cmd.scan && scan_done && mode_reg == MODE_REMOVE)
            begin
                count_reg <= kept_reg;
            end
            else
            begin
                count_reg <= count_reg;
            end

            if (cmd.fin || cmd.dump_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg        <= req_data.mode;
            key_addr_reg    <= req_data.address[AW-1:0];
            key_len_reg     <= req_data.length;
            res_addr_reg    <= '0;
            res_len_reg     <= '0;
            res_status_reg  <= ST_OK;
            res_removed_reg <= '0;
        end

        if (cmd.exec)
        begin
            if (mode_reg == MODE_APPEND && full)
            begin
                res_status_reg <= ST_FULL;
            end
            if (mode_reg == MODE_DUMP && count_reg == '0)
            begin
                res_status_reg <= ST_MISS;
            end
        end

        if (cmd.scan)
        begin
            if (stop_hit && !res_found_reg)
            begin
                res_addr_reg <= ent_addr;
                res_len_reg  <= ent_len;
            end
            if (scan_done)
            begin
                if (mode_reg == MODE_REMOVE)
                begin
                    res_removed_reg <= count_reg - kept_reg;
                    res_status_reg  <= (count_reg == kept_reg) ? ST_MISS : ST_OK;
                end
                else if (!res_found_reg)
                begin
                    res_status_reg <= ST_MISS;
                end
            end
        end

        if (cmd.dump_out)
        begin
            out_reg.found       <= 1'b1;
            out_reg.rec_address <= ADDR_W'(ent_addr);
            out_reg.rec_length  <= ent_len;
            out_reg.status      <= ST_OK;
            out_reg.removed     <= '0;
            out_reg.entries     <= COUNT_W'(count_reg);
            out_reg.last        <= dump_last;
        end
        else if (cmd.fin)
        begin
            out_reg.found       <= res_found_reg;
            out_reg.rec_address <= ADDR_W'(res_addr_reg);
            out_reg.rec_length  <= res_len_reg;
            out_reg.status      <= res_status_reg;
            out_reg.removed     <= COUNT_W'(res_removed_reg);
            out_reg.entries     <= COUNT_W'(count_reg);
            out_reg.last        <= 1'b1;
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_done = scan_done;
    assign sts.dump_last = dump_last;
    assign sts.out_free  = out_free;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

>>> rtl/allocation_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation record table
// Ordered first-fit table of (address, size) records with search,
// order-keeping removal, clear and dump.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer (mode, address, length); rsp returns
//   result transfers. Every command yields one result with last set, except a
//   dump of a non-empty table, which yields one result per record in table
//   order with last set on the final one.
//   A command is taken only while the block is idle. Append, clear and the
//   unused modes pass through the execute step, then the result load. Find,
//   first fit and remove walk the table one record per cycle through the
//   single read port of the record memory; find and first fit stop at the
//   first hit. A dump reads each record from memory, then loads it into the
//   output register.
//   The result sits in an output register; the next command is accepted
//   while it waits. If rsp stalls, a following result waits in its final
//   step, and a dump pauses between records until the register frees up.
//   Reset empties the table (fill count zero) and clears the output valid;
//   record memory contents are not touched.
// ----------------------------------------------------------------------------
`include "allocation_record_table_defines.svh"

module allocation_record_table #(
    parameter int DEPTH     = art_pkg::DEPTH_DEFAULT,
    parameter int ADDR_BITS = art_pkg::ADDR_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    art_req_if.sink    req,
    art_rsp_if.source  rsp
);
    import art_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;
    logic       in_ready;

    // sequencing: decode, walk, result load
    art_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // record memory, counters, compare and output register
    art_dp #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

    // no result is loaded while the controller is waiting for a command
    `ART_ASSERT_SAME(a_idle_no_load, req.ready, !(cmd.fin || cmd.dump_out), "load while idle")
    // a command is worked on one at a time
    `ART_ASSERT_NEXT(a_busy_after_xfer, req.valid && req.ready, !req.ready, "ready after accept")
    // output register is never overwritten while holding an untaken result
    `ART_ASSERT_SAME(a_load_free, cmd.fin || cmd.dump_out, sts.out_free, "output overwritten")
    // every load shows up as a valid result
    `ART_ASSERT_NEXT(a_load_valid, cmd.fin || cmd.dump_out, rsp.valid, "result lost")

endmodule
